// ===== design/bgbo_pkg.sv =====
package bgbo_pkg;

    // Grid geometry. Entries are stored at row * MAX_COLS + col.
    localparam int MAX_ROWS = 8;
    localparam int MAX_COLS = 8;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int RCNT_W   = $clog2(MAX_ROWS + 1);
    localparam int CCNT_W   = $clog2(MAX_COLS + 1);

    // Field widths of the words on the two channels.
    localparam int FUNC_W = 2;
    localparam int POS_W  = 16;
    localparam int SEL_W  = 3;
    localparam int HGT_W  = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;
    localparam logic [CFG_DATA_W-1:0] RST_ROWS = 4'd5;
    localparam logic [CFG_DATA_W-1:0] RST_COLS = 4'd5;

    // Function codes of an input word.
    localparam logic [FUNC_W-1:0] FN_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FN_QUERY = 2'd2;

    // Fixed-point widths. A fraction is -255..255, a weight 1..511.
    localparam int FRAC_ONE = 256;
    localparam int FR_W     = 9;
    localparam int MP_W     = 10;
    localparam int MC_W     = 18;
    localparam int PROD_W   = 28;
    localparam int TERM_W   = PROD_W - 8;
    localparam int Z_W      = TERM_W + 1;
    localparam int MCNT_W   = $clog2(MP_W);

    typedef struct packed {
        logic                     start;
        logic signed [MC_W-1:0]   mcand;
        logic signed [MP_W-1:0]   mplier;
    } t_mul_req;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] prod;
    } t_mul_rsp;

    // Divide by 256, truncating toward zero.
    function automatic logic signed [TERM_W-1:0] trunc8(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] adj;
        adj = p[PROD_W-1] ? p + PROD_W'(255) : p;
        return adj[PROD_W-1:8];
    endfunction

endpackage

// ===== design/bgbo_if.sv =====
interface bgbo_req_if import bgbo_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [POS_W-1:0]  x_pos;
    logic signed [POS_W-1:0]  y_pos;
    logic [SEL_W-1:0]         row_sel;
    logic [SEL_W-1:0]         col_sel;
    logic signed [HGT_W-1:0]  height_value;

    modport source (output valid, func, x_pos, y_pos, row_sel, col_sel, height_value,
                    input ready);
    modport sink   (input valid, func, x_pos, y_pos, row_sel, col_sel, height_value,
                    output ready);
endinterface

interface bgbo_rsp_if import bgbo_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [HGT_W-1:0]  z_offset;
    logic                     outside_grid;

    modport source (output valid, z_offset, outside_grid, input ready);
    modport sink   (input valid, z_offset, outside_grid, output ready);
endinterface

// ===== design/bgbo_ser_mul.sv =====
module bgbo_ser_mul import bgbo_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    // Radix-2 shift-add multiplier: one multiplier bit per cycle, with the
    // top bit carrying negative weight.
    logic                     r_busy;
    logic                     r_done;
    logic [MCNT_W-1:0]        r_cnt;
    logic signed [PROD_W-1:0] r_mc;
    logic [MP_W-1:0]          r_mpl;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [PROD_W-1:0] w_addend;
    logic                     w_last;

    assign w_addend = r_mpl[0] ? r_mc : '0;
    assign w_last   = (r_cnt == MCNT_W'(MP_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mc  <= PROD_W'(i_req.mcand);
            r_mpl <= i_req.mplier;
            r_cnt <= '0;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= w_last ? r_acc - w_addend : r_acc + w_addend;
            r_mc  <= r_mc <<< 1;
            r_mpl <= r_mpl >> 1;
            r_cnt <= r_cnt + MCNT_W'(1);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

// ===== design/bed_grid_bilinear_offset.sv =====
// A write or clear word is taken in idle, and the block is ready again next cycle.
// A query inside the grid yields its result word after six products run one after another
// through a bit-serial multiplier, each corner being read from the grid before its product;
// the next word is taken no sooner than the result word is loaded into the output register.
// A query outside the grid skips the reads and products and goes straight to its result.
// Reset (synchronous, active low) marks every grid entry as zero and sets both counts to 5.
module bed_grid_bilinear_offset import bgbo_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bgbo_req_if.sink              i_req,
    bgbo_rsp_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_GO   = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    // Steps of a query. Steps 0..3 take one corner each from the grid,
    // step 4 weights the second row blend and step 5 the first.
    localparam logic [2:0] STEP_A    = 3'd0;
    localparam logic [2:0] STEP_B    = 3'd1;
    localparam logic [2:0] STEP_C    = 3'd2;
    localparam logic [2:0] STEP_D    = 3'd3;
    localparam logic [2:0] STEP_FY   = 3'd4;
    localparam logic [2:0] STEP_LAST = 3'd5;

    localparam int Z_MAX = 32767;
    localparam int Z_MIN = -32768;

    function automatic logic [ADDR_W-1:0] grid_addr(input int row, input int col);
        return ADDR_W'(row * MAX_COLS + col);
    endfunction

    // Configuration registers and their effective counts. A zero count acts
    // as one and a count above the grid size acts as the grid size.
    logic [CFG_DATA_W-1:0] r_rows;
    logic [CFG_DATA_W-1:0] r_cols;
    logic [RCNT_W-1:0]     w_nr;
    logic [CCNT_W-1:0]     w_nc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= RST_ROWS;
            r_cols <= RST_COLS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS: r_rows <= i_cfg_data;
                CFG_COLS: r_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_rows == '0) begin
            w_nr = RCNT_W'(1);
        end else if (int'(r_rows) > MAX_ROWS) begin
            w_nr = RCNT_W'(MAX_ROWS);
        end else begin
            w_nr = RCNT_W'(r_rows);
        end
        if (r_cols == '0) begin
            w_nc = CCNT_W'(1);
        end else if (int'(r_cols) > MAX_COLS) begin
            w_nc = CCNT_W'(MAX_COLS);
        end else begin
            w_nc = CCNT_W'(r_cols);
        end
    end

    // Control registers.
    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [2:0] r_step;
    logic [2:0] n_step;

    logic w_accept;
    logic w_query;
    logic w_wr;
    logic w_clr;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_query     = w_accept && (i_req.func == FN_QUERY);
    assign w_clr       = w_accept && (i_req.func == FN_CLEAR);
    assign w_wr        = w_accept && (i_req.func == FN_WRITE)
                         && (int'(i_req.row_sel) < int'(w_nr))
                         && (int'(i_req.col_sel) < int'(w_nc));

    // Query decode. Truncation toward zero: a negative coordinate with a
    // nonzero fraction moves its cell up by one and keeps a negative fraction.
    logic                  w_xneg;
    logic                  w_yneg;
    logic signed [8:0]     w_xi;
    logic signed [8:0]     w_yi;
    logic signed [FR_W-1:0] w_fx;
    logic signed [FR_W-1:0] w_fy;
    logic                  w_outside;
    logic [ROW_W-1:0]      w_xa;
    logic [ROW_W-1:0]      w_xb;
    logic [COL_W-1:0]      w_ya;
    logic [COL_W-1:0]      w_yb;

    assign w_xneg = i_req.x_pos[POS_W-1] && (i_req.x_pos[7:0] != '0);
    assign w_yneg = i_req.y_pos[POS_W-1] && (i_req.y_pos[7:0] != '0);
    assign w_xi   = 9'($signed(i_req.x_pos[POS_W-1:8])) + (w_xneg ? 9'sd1 : 9'sd0);
    assign w_yi   = 9'($signed(i_req.y_pos[POS_W-1:8])) + (w_yneg ? 9'sd1 : 9'sd0);
    assign w_fx   = {w_xneg, i_req.x_pos[7:0]};
    assign w_fy   = {w_yneg, i_req.y_pos[7:0]};

    assign w_outside = (int'(w_xi) < 0) || (int'(w_xi) >= int'(w_nr))
                    || (int'(w_yi) < 0) || (int'(w_yi) >= int'(w_nc));

    // The neighbor of the last row or column in use is that row or column.
    assign w_xa = ROW_W'(w_xi);
    assign w_ya = COL_W'(w_yi);
    assign w_xb = (int'(w_xi) == int'(w_nr) - 1) ? w_xa : w_xa + ROW_W'(1);
    assign w_yb = (int'(w_yi) == int'(w_nc) - 1) ? w_ya : w_ya + COL_W'(1);

    // Grid memory with one valid bit per entry; an entry that is not valid
    // reads as zero, so a clear only drops the valid bits.
    logic [HGT_W-1:0]  r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [HGT_W-1:0]  r_rdata;
    logic              r_rvld;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr;

    logic [ROW_W-1:0] r_xa;
    logic [ROW_W-1:0] r_xb;
    logic [COL_W-1:0] r_ya;
    logic [COL_W-1:0] r_yb;

    assign w_waddr = grid_addr(int'(i_req.row_sel), int'(i_req.col_sel));

    always_comb begin
        case (r_step)
            STEP_A:  w_raddr = grid_addr(int'(r_xa), int'(r_ya));
            STEP_B:  w_raddr = grid_addr(int'(r_xb), int'(r_ya));
            STEP_C:  w_raddr = grid_addr(int'(r_xa), int'(r_yb));
            STEP_D:  w_raddr = grid_addr(int'(r_xb), int'(r_yb));
            default: w_raddr = grid_addr(int'(r_xa), int'(r_ya));
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clr) begin
            r_vld <= '0;
        end else if (w_wr) begin
            r_vld[w_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[w_waddr] <= i_req.height_value;
        end
        r_rdata <= r_mem[w_raddr];
        r_rvld  <= r_vld[w_raddr];
    end

    // Operands and partial results of the blend.
    logic signed [FR_W-1:0]   r_fx;
    logic signed [FR_W-1:0]   r_fy;
    logic signed [TERM_W-1:0] r_acc;
    logic signed [MC_W-1:0]   r_r1;
    logic signed [MC_W-1:0]   r_r2;
    logic [HGT_W-1:0]         r_z;
    logic                     r_zout;

    logic signed [MP_W-1:0]   w_fx_e;
    logic signed [MP_W-1:0]   w_fy_e;
    logic signed [MP_W-1:0]   w_wx;
    logic signed [MP_W-1:0]   w_wy;
    logic signed [MC_W-1:0]   w_corner;
    logic signed [TERM_W-1:0] w_term;
    logic signed [Z_W-1:0]    w_sum;
    logic [HGT_W-1:0]         w_sat;

    t_mul_req w_mreq;
    t_mul_rsp w_mrsp;

    assign w_fx_e   = MP_W'(r_fx);
    assign w_fy_e   = MP_W'(r_fy);
    assign w_wx     = MP_W'(FRAC_ONE) - w_fx_e;
    assign w_wy     = MP_W'(FRAC_ONE) - w_fy_e;
    assign w_corner = r_rvld ? MC_W'($signed(r_rdata)) : '0;

    always_comb begin
        w_mreq.start = (r_state == S_GO);
        case (r_step)
            STEP_A: begin
                w_mreq.mcand  = w_corner;
                w_mreq.mplier = w_wx;
            end
            STEP_B: begin
                w_mreq.mcand  = w_corner;
                w_mreq.mplier = w_fx_e;
            end
            STEP_C: begin
                w_mreq.mcand  = w_corner;
                w_mreq.mplier = w_wx;
            end
            STEP_D: begin
                w_mreq.mcand  = w_corner;
                w_mreq.mplier = w_fx_e;
            end
            STEP_FY: begin
                w_mreq.mcand  = r_r2;
                w_mreq.mplier = w_fy_e;
            end
            default: begin
                w_mreq.mcand  = r_r1;
                w_mreq.mplier = w_wy;
            end
        endcase
    end

    bgbo_ser_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_rsp   (w_mrsp)
    );

    // Each product is truncated toward zero before it is added to its pair.
    assign w_term = trunc8(w_mrsp.prod);
    assign w_sum  = Z_W'(r_acc) + Z_W'(w_term);

    always_comb begin
        if (int'(w_sum) > Z_MAX) begin
            w_sat = HGT_W'(Z_MAX);
        end else if (int'(w_sum) < Z_MIN) begin
            w_sat = HGT_W'(Z_MIN);
        end else begin
            w_sat = w_sum[HGT_W-1:0];
        end
    end

    // Sequencer: read a corner, start the multiplier, wait for its product.
    // The last two steps need no read and start right away.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (w_query) begin
                    n_step  = STEP_A;
                    n_state = w_outside ? S_FIN : S_RD;
                end
            end
            S_RD: begin
                n_state = S_GO;
            end
            S_GO: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_mrsp.done) begin
                    if (r_step == STEP_LAST) begin
                        n_state = S_FIN;
                    end else begin
                        n_step  = r_step + 3'd1;
                        n_state = (r_step < STEP_D) ? S_RD : S_GO;
                    end
                end
            end
            S_FIN: begin
                if (!o_rsp.valid || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= STEP_A;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_xa   <= w_xa;
            r_xb   <= w_xb;
            r_ya   <= w_ya;
            r_yb   <= w_yb;
            r_fx   <= w_fx;
            r_fy   <= w_fy;
            r_z    <= '0;
            r_zout <= w_outside;
        end
        if (r_state == S_WAIT && w_mrsp.done) begin
            case (r_step)
                STEP_B:    r_r1 <= MC_W'(w_sum);
                STEP_D:    r_r2 <= MC_W'(w_sum);
                STEP_LAST: begin
                    r_z    <= w_sat;
                    r_zout <= 1'b0;
                end
                default:   r_acc <= w_term;
            endcase
        end
    end

    // Output register: the finished word waits here, so the sequencer goes
    // back to idle and takes the next input word while this one is pending.
    logic             r_ovalid;
    logic [HGT_W-1:0] r_oz;
    logic             r_oout;
    logic             w_load;

    assign w_load = (r_state == S_FIN) && (!r_ovalid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_oz   <= r_z;
            r_oout <= r_zout;
        end
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.z_offset     = r_oz;
    assign o_rsp.outside_grid = r_oout;

`ifndef SYNTHESIS
    // The multiplier only finishes while the sequencer waits for it.
    a_mul_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mrsp.done |-> (r_state == S_WAIT))
        else $error("multiplier finished outside its wait state");

    // A query occupies the block, so nothing else is taken on the next cycle.
    a_query_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.func == FN_QUERY) |=> !i_req.ready)
        else $error("input taken right after a query");

    // A position outside the grid always reports a zero offset.
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.outside_grid) |-> (o_rsp.z_offset == '0))
        else $error("outside flag with nonzero offset");
`endif

endmodule
